/* hw/rtl/hbwc_pkg.sv */
// Package: beat types, opcodes and field widths of the hourly bucket window counter.
package hbwc_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned MinuteW = 6;

  typedef enum logic [OpcodeW-1:0] {
    OpAdd      = 3'd0,
    OpTick     = 3'd1,
    OpSetTotal = 3'd2,
    OpReset    = 3'd3,
    OpRead     = 3'd4
  } op_e;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [ValueW-1:0]  value;
    logic [IndexW-1:0]  bucket_index;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0]  window_sum;
    logic [ValueW-1:0]  grand_total;
    logic [MinuteW-1:0] minutes_in_hour;
    logic [ValueW-1:0]  bucket_value;
  } out_beat_t;

endpackage

/* hw/rtl/hbwc_if.sv */
// Interfaces: valid/ready channels for request and result beats.
interface hbwc_in_if;
  logic               valid;
  logic               ready;
  hbwc_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hbwc_out_if;
  logic                valid;
  logic                ready;
  hbwc_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hourly_bucket_window_counter_top.sv */
// Top level: hourly bucket window counter with request and result channels.
//
// Usage:
//   in_i  carries request beats {opcode, value, bucket_index}; out_o carries
//   result beats {window_sum, grand_total, minutes_in_hour, bucket_value}.
//   Opcodes: add, minute tick, set grand total, reset all, read only; the
//   unused codes act as read only. Every request gives exactly one result
//   that shows the state after the request has taken effect.
// Timing:
//   The result of an accepted beat is registered and valid on out_o right
//   after the edge that accepted it. One beat is taken per cycle while no
//   result waits on out_o.ready: all update work is one pass of adders and
//   a bucket select between the state registers and the result register.
// Reset:
//   rst_ni clears all buckets, the window sum, the grand total and the
//   minute counter, and empties the result register.
// Stall:
//   While a result waits and out_o.ready is low, in_i.ready drops; a new
//   request is taken in the same cycle that the waiting result leaves.
module hourly_bucket_window_counter_top #(
  parameter int unsigned NUM_BUCKETS        = 24,
  parameter int unsigned MINUTES_PER_BUCKET = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hbwc_in_if.sink     in_i,
  hbwc_out_if.source  out_o
);

  logic                accept;
  logic                out_valid_q, out_valid_d;
  hbwc_pkg::out_beat_t out_data_q;
  hbwc_pkg::out_beat_t result;

  // Take a beat whenever the result register is empty or is being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  hbwc_state #(
    .NUM_BUCKETS        (NUM_BUCKETS),
    .MINUTES_PER_BUCKET (MINUTES_PER_BUCKET)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_i.data),
    .result_o (result)
  );

  // Hold the result until taken; load a fresh one on every accepted beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

/* hw/rtl/hbwc_state.sv */
// State and update logic: hourly buckets, window sum, grand total, minute counter.
module hbwc_state #(
  parameter int unsigned NUM_BUCKETS        = 24,
  parameter int unsigned MINUTES_PER_BUCKET = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hbwc_pkg::in_beat_t  beat_i,
  output hbwc_pkg::out_beat_t result_o
);

  localparam int unsigned IdxW = $clog2(NUM_BUCKETS);
  localparam int unsigned MinW = $clog2(MINUTES_PER_BUCKET);
  localparam int unsigned VW   = hbwc_pkg::ValueW;
  localparam logic [MinW-1:0] MinLast = MinW'(MINUTES_PER_BUCKET - 1);

  logic [VW-1:0]   buckets_q [NUM_BUCKETS];
  logic [VW-1:0]   buckets_d [NUM_BUCKETS];
  logic [VW-1:0]   window_q, window_d;
  logic [VW-1:0]   total_q, total_d;
  logic [MinW-1:0] minute_q, minute_d;

  hbwc_pkg::op_e             op;
  logic                      rollover;
  logic                      in_range;
  logic [IdxW+hbwc_pkg::IndexW-1:0] idx_ext;
  logic [IdxW-1:0]           idx;
  logic [MinW+hbwc_pkg::MinuteW-1:0] minute_ext;

  assign op       = hbwc_pkg::op_e'(beat_i.opcode);
  assign rollover = (minute_q == MinLast);

  always_comb begin
    buckets_d = buckets_q;
    window_d  = window_q;
    total_d   = total_q;
    minute_d  = minute_q;
    unique case (op)
      hbwc_pkg::OpAdd: begin
        buckets_d[0] = buckets_q[0] + beat_i.value;
        window_d     = window_q + beat_i.value;
        total_d      = total_q + beat_i.value;
      end
      hbwc_pkg::OpTick: begin
        if (rollover) begin
          // New hour: drop the oldest bucket and shift the rest
          minute_d = '0;
          window_d = window_q - buckets_q[NUM_BUCKETS-1];
          for (int k = NUM_BUCKETS - 1; k > 0; k--) begin
            buckets_d[k] = buckets_q[k-1];
          end
          buckets_d[0] = '0;
        end else begin
          minute_d = minute_q + 1'b1;
        end
      end
      hbwc_pkg::OpSetTotal: begin
        total_d = beat_i.value;
      end
      hbwc_pkg::OpReset: begin
        for (int k = 0; k < NUM_BUCKETS; k++) begin
          buckets_d[k] = '0;
        end
        window_d = '0;
        total_d  = '0;
        minute_d = '0;
      end
      hbwc_pkg::OpRead: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        buckets_q[k] <= '0;
      end
      window_q <= '0;
      total_q  <= '0;
      minute_q <= '0;
    end else if (accept_i) begin
      buckets_q <= buckets_d;
      window_q  <= window_d;
      total_q   <= total_d;
      minute_q  <= minute_d;
    end
  end

  // Report the state after this beat has taken effect
  assign in_range   = 32'(beat_i.bucket_index) < 32'(NUM_BUCKETS);
  assign idx_ext    = (IdxW + hbwc_pkg::IndexW)'(beat_i.bucket_index);
  assign idx        = idx_ext[IdxW-1:0];
  assign minute_ext = (MinW + hbwc_pkg::MinuteW)'(minute_d);

  assign result_o.window_sum      = window_d;
  assign result_o.grand_total     = total_d;
  assign result_o.minutes_in_hour = minute_ext[hbwc_pkg::MinuteW-1:0];
  assign result_o.bucket_value    = in_range ? buckets_d[idx] : '0;

`ifndef SYNTH
  a_minute_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(minute_q) < 32'(MINUTES_PER_BUCKET))
    else $error("minute counter out of range");

  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (op == hbwc_pkg::OpReset)
      |=> (window_q == '0) && (total_q == '0) && (minute_q == '0))
    else $error("reset-all beat left state behind");

  a_add_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (op == hbwc_pkg::OpAdd)
      |=> total_q == $past(total_q) + $past(beat_i.value))
    else $error("grand total missed an add");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(window_q) && $stable(total_q) && $stable(minute_q))
    else $error("state moved without an accepted beat");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench: checks the hourly bucket window counter beat by beat against its own predictor.
module tb_top;

  localparam int unsigned NumBuckets       = 24;
  localparam int unsigned MinutesPerBucket = 60;

  // Codes the block does not define; they must behave as read only.
  localparam logic [hbwc_pkg::OpcodeW-1:0] OpSpare5 = 3'd5;
  localparam logic [hbwc_pkg::OpcodeW-1:0] OpSpare6 = 3'd6;
  localparam logic [hbwc_pkg::OpcodeW-1:0] OpSpare7 = 3'd7;

  logic clk_i;
  logic rst_ni;

  hbwc_in_if  in_ch ();
  hbwc_out_if out_ch ();

  hourly_bucket_window_counter_top #(
    .NUM_BUCKETS        (NumBuckets),
    .MINUTES_PER_BUCKET (MinutesPerBucket)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Own copy of the counter state, advanced once per accepted request beat.
  logic [hbwc_pkg::ValueW-1:0] model_buckets [NumBuckets];
  logic [hbwc_pkg::ValueW-1:0] model_window;
  logic [hbwc_pkg::ValueW-1:0] model_grand;
  int unsigned                 model_minutes;

  hbwc_pkg::out_beat_t expected_results [$];
  int unsigned         mismatch_count;
  // Set for stretches where neither side idles, so back-to-back beats occur.
  bit                  steady_flow;

  function automatic void clear_counter_model();
    foreach (model_buckets[k]) model_buckets[k] = '0;
    model_window  = '0;
    model_grand   = '0;
    model_minutes = 0;
  endfunction

  // Apply one request to the model state and return the result it must give.
  function automatic hbwc_pkg::out_beat_t predict_counter(hbwc_pkg::in_beat_t req);
    hbwc_pkg::out_beat_t res;
    case (req.opcode)
      hbwc_pkg::OpAdd: begin
        model_buckets[0] += req.value;
        model_window     += req.value;
        model_grand      += req.value;
      end
      hbwc_pkg::OpTick: begin
        model_minutes++;
        // Start a new hour: retire the oldest bucket and shift the rest.
        if (model_minutes >= MinutesPerBucket) begin
          model_minutes = 0;
          model_window -= model_buckets[NumBuckets-1];
          for (int k = NumBuckets - 1; k > 0; k--) model_buckets[k] = model_buckets[k-1];
          model_buckets[0] = '0;
        end
      end
      hbwc_pkg::OpSetTotal: model_grand = req.value;
      hbwc_pkg::OpReset:    clear_counter_model();
      default: ;
    endcase
    res.window_sum      = model_window;
    res.grand_total     = model_grand;
    res.minutes_in_hour = model_minutes[hbwc_pkg::MinuteW-1:0];
    res.bucket_value    = (req.bucket_index < NumBuckets) ?
                          model_buckets[req.bucket_index] : '0;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [hbwc_pkg::ValueW-1:0] got,
                                 logic [hbwc_pkg::ValueW-1:0] want);
    mismatch_count++;
    $display("mismatch on %0s: got %h, expected %h", field, got, want);
  endtask

  function automatic hbwc_pkg::in_beat_t make_req(logic [hbwc_pkg::OpcodeW-1:0] op,
                                                  logic [hbwc_pkg::ValueW-1:0]  val,
                                                  logic [hbwc_pkg::IndexW-1:0]  idx);
    hbwc_pkg::in_beat_t req;
    req.opcode       = op;
    req.value        = val;
    req.bucket_index = idx;
    return req;
  endfunction

  // Mix small, full-width, near-max and single-bit amounts.
  function automatic logic [hbwc_pkg::ValueW-1:0] rand_amount();
    case ($urandom_range(0, 3))
      0:       return hbwc_pkg::ValueW'($urandom_range(0, 255));
      1:       return {$urandom, $urandom};
      2:       return '1 - hbwc_pkg::ValueW'($urandom_range(0, 255));
      default: return hbwc_pkg::ValueW'(1) << $urandom_range(0, hbwc_pkg::ValueW - 1);
    endcase
  endfunction

  // Send one request beat. Called right after a rising edge; returns right
  // after the edge that accepted the beat, with valid still high so that a
  // following beat with no gap goes out back to back.
  task automatic send_req(hbwc_pkg::in_beat_t req);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk_i); while (!in_ch.ready);
    // Predict in acceptance order.
    expected_results.push_back(predict_counter(req));
  endtask

  // Extremes of every field, every opcode and the named corner cases.
  task automatic test_directed_extremes();
    send_req(make_req(hbwc_pkg::OpRead, '0, 5'd0));
    send_req(make_req(hbwc_pkg::OpAdd, '1, 5'd0));                  // max amount
    send_req(make_req(hbwc_pkg::OpAdd, 64'd1, 5'd0));               // wrap bucket, window, total
    // Index beyond the last bucket
    send_req(make_req(hbwc_pkg::OpAdd, 64'h8000_0000_0000_0000, 5'd31));
    send_req(make_req(hbwc_pkg::OpRead, '0, 5'd23));                // oldest bucket
    send_req(make_req(hbwc_pkg::OpRead, '0, 5'd24));                // first index out of range
    send_req(make_req(hbwc_pkg::OpSetTotal, '1, 5'd0));             // total only
    send_req(make_req(hbwc_pkg::OpAdd, 64'd2, 5'd0));               // grand total wraps
    send_req(make_req(hbwc_pkg::OpSetTotal, '0, 5'd16));
    send_req(make_req(hbwc_pkg::OpTick, '1, 5'd0));                 // value ignored on tick
    send_req(make_req(OpSpare5, '1, 5'd0));
    send_req(make_req(OpSpare6, 64'h5555_5555_5555_5555, 5'd1));
    send_req(make_req(OpSpare7, 64'hAAAA_AAAA_AAAA_AAAA, 5'd2));
    send_req(make_req(hbwc_pkg::OpReset, '1, 5'd0));                // clear everything
    send_req(make_req(hbwc_pkg::OpRead, '1, 5'd0));
    send_req(make_req(hbwc_pkg::OpAdd, 64'h0123_4567_89AB_CDEF, 5'd0));
    send_req(make_req(hbwc_pkg::OpRead, '0, 5'd31));
  endtask

  // Random mix of all opcodes, resets included.
  task automatic test_random_mix(int unsigned beats);
    int unsigned                  pick;
    logic [hbwc_pkg::OpcodeW-1:0] op;
    for (int unsigned i = 0; i < beats; i++) begin
      if (i % 64 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = hbwc_pkg::OpAdd;
      else if (pick < 60) op = hbwc_pkg::OpTick;
      else if (pick < 72) op = hbwc_pkg::OpRead;
      else if (pick < 80) op = hbwc_pkg::OpSetTotal;
      else if (pick < 83) op = hbwc_pkg::OpReset;
      else                op = hbwc_pkg::OpcodeW'($urandom_range(OpSpare5, OpSpare7));
      send_req(make_req(op, rand_amount(), hbwc_pkg::IndexW'($urandom_range(0, 31))));
    end
  endtask

  // Mostly ticks with adds in between and no resets, so that more than a
  // full day passes and filled buckets age out of the window.
  task automatic test_window_expiry(int unsigned beats);
    int unsigned                  pick;
    logic [hbwc_pkg::OpcodeW-1:0] op;
    for (int unsigned i = 0; i < beats; i++) begin
      if (i % 64 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 92)      op = hbwc_pkg::OpTick;
      else if (pick < 98) op = hbwc_pkg::OpAdd;
      else if (pick < 99) op = hbwc_pkg::OpRead;
      else                op = hbwc_pkg::OpSetTotal;
      send_req(make_req(op, rand_amount(), hbwc_pkg::IndexW'($urandom_range(0, 31))));
    end
  endtask

  // Result side: stall a random number of cycles before each beat, then
  // compare the beat field by field with the oldest prediction.
  initial begin : result_checker
    int unsigned         stall;
    hbwc_pkg::out_beat_t got;
    hbwc_pkg::out_beat_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", got.window_sum, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.window_sum !== want.window_sum)
          report_mismatch("window_sum", got.window_sum, want.window_sum);
        if (got.grand_total !== want.grand_total)
          report_mismatch("grand_total", got.grand_total, want.grand_total);
        if (got.minutes_in_hour !== want.minutes_in_hour)
          report_mismatch("minutes_in_hour", hbwc_pkg::ValueW'(got.minutes_in_hour),
                          hbwc_pkg::ValueW'(want.minutes_in_hour));
        if (got.bucket_value !== want.bucket_value)
          report_mismatch("bucket_value", got.bucket_value, want.bucket_value);
      end
    end
  end

  // Main sequence: reset once, run the tests, drain, then decide.
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    mismatch_count = 0;
    steady_flow    = 1'b0;
    clear_counter_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_mix(350);
    test_window_expiry(1600);

    // Drop valid after the last beat and wait for every result to come back.
    in_ch.valid <= 1'b0;
    steady_flow = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // Keep running past the drain to catch any stray result beat.
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run; a correct run ends far earlier.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
